// File: rtl/ast_pkg.sv
// Package for the age-stamped slot table.
// Stamp codes, command codes, status codes and the structs passed between modules.
// No dependencies.
package ast_pkg;

    // Stamp codes
    localparam logic [7:0] STAMP_EMPTY    = 8'hFF;
    localparam logic [7:0] STAMP_DELETED  = 8'h00;
    localparam logic [7:0] STAMP_MAX_LIVE = 8'd254;

    // Command codes carried by the request channel
    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_SLOT = 1'b1;

    // Write-side control of the stamp store
    typedef struct packed {
        logic       clear;
        logic       wr_en;
        logic [7:0] wr_data;
    } st_ctl_t;

    // Classification and compare results of the shared compare unit
    typedef struct packed {
        logic       is_empty;
        logic       is_deleted;
        logic       is_live;
        logic       lt_min;
        logic       gt_max;
        logic       listed;
        logic [7:0] key;
        logic       before_ref;
    } cmp_res_t;

endpackage

// File: rtl/ast_cmd_if.sv
// Request channel of the age-stamped slot table: valid/ready plus command payload.
// Depends on nothing.
interface ast_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [3:0] slot_index;

    modport source (output valid, output command, output slot_index, input ready);
    modport sink   (input valid, input command, input slot_index, output ready);
endinterface

// File: rtl/ast_res_if.sv
// Response channel of the age-stamped slot table: valid/ready plus result payload.
// Depends on nothing.
interface ast_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] slot;
    logic [7:0] entry_stamp;
    logic       status;
    logic       renumbered;

    modport source (output valid, output slot, output entry_stamp, output status,
                    output renumbered, input ready);
    modport sink   (input valid, input slot, input entry_stamp, input status,
                    input renumbered, output ready);
endinterface

// File: rtl/ast_stamp_store.sv
// Stamp storage: one write port, one registered read port, per-slot valid bits.
// An entry whose valid bit is clear reads as the empty stamp. Depends on ast_pkg.
module ast_stamp_store #(
    parameter int SLOT_COUNT = 16,
    localparam int IDX_W = $clog2(SLOT_COUNT)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ast_pkg::st_ctl_t     ctl,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [7:0]           rd_data
);

    logic [7:0]            mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [7:0]            mem_q_reg;
    logic                  vld_q_reg;

    // Memory array: write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= ctl.wr_data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // Valid bits: clear empties every slot at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            vld_q_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = vld_q_reg ? mem_q_reg : ast_pkg::STAMP_EMPTY;

endmodule

// File: rtl/ast_cmp_unit.sv
// Shared compare unit: classifies one stamp and compares it against the running
// minimum, maximum and the rank reference. Depends on ast_pkg.
module ast_cmp_unit #(
    parameter int IDX_W = 4
) (
    input  logic [7:0]        stamp,
    input  logic [IDX_W-1:0]  cur_idx,
    input  logic [IDX_W-1:0]  chosen_idx,
    input  logic [7:0]        min_s,
    input  logic [7:0]        max_s,
    input  logic [7:0]        ref_key,
    input  logic [IDX_W-1:0]  ref_idx,
    output ast_pkg::cmp_res_t res
);

    logic is_chosen;

    always_comb
    begin
        is_chosen      = (cur_idx == chosen_idx);
        res.is_empty   = (stamp == ast_pkg::STAMP_EMPTY);
        res.is_deleted = (stamp == ast_pkg::STAMP_DELETED);
        res.is_live    = !res.is_empty && !res.is_deleted;
        res.lt_min     = (stamp < min_s);
        res.gt_max     = (stamp > max_s);
        // chosen slot ranks last among the renumbered ones
        res.listed     = is_chosen || res.is_live;
        res.key        = is_chosen ? ast_pkg::STAMP_EMPTY : stamp;
        // (key, slot) ordering, ties kept in slot order
        res.before_ref = (res.key < ref_key) || ((res.key == ref_key) && (cur_idx < ref_idx));
    end

endmodule

// File: rtl/age_stamped_slot_table.sv
// Top level of the age-stamped slot table: command sequencer, rank memory, output stage.
// Depends on ast_pkg, ast_cmd_if, ast_res_if, ast_stamp_store and ast_cmp_unit.
//
//  channel    | dir | handshake          | payload
//  -----------+-----+--------------------+------------------------------------------
//  request    | in  | valid/ready        | command[1:0], slot_index[3:0]
//  response   | out | valid/ready        | slot[3:0], entry_stamp[7:0], status, renumbered
//  cfg        | in  | cfg_wr_en          | cfg_wr_data (reuse_deleted)
//
// Stamps are read one per cycle through the single read port of the stamp store and scanned
// by one shared compare unit. A put that renumbers adds one pairwise compare per cycle for
// every slot, then a copy of the rank memory back into the stamp store.
// Reset and clear empty every slot at once through per-slot valid bits; no clearing pass.
// request.ready is high only while the sequencer is idle; a finished result waits in the
// response register while the next transaction is taken.
module age_stamped_slot_table #(
    parameter int SLOT_COUNT = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    ast_cmd_if.sink       request,
    ast_res_if.source     response
);

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int RANK_W = CNT_W;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DECIDE,
        S_RN_LOAD,
        S_RN_KEY,
        S_RN_INNER,
        S_COPY,
        S_FIN
    } state_t;

    state_t              state_reg, state_next;
    logic                reuse_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [IDX_W-1:0]    oi_reg, oi_next;
    logic [7:0]          min_s_reg, min_s_next;
    logic [IDX_W-1:0]    min_i_reg, min_i_next;
    logic                have_min_reg, have_min_next;
    logic [7:0]          max_s_reg, max_s_next;
    logic                have_empty_reg, have_empty_next;
    logic [IDX_W-1:0]    empty_i_reg, empty_i_next;
    logic                have_del_reg, have_del_next;
    logic [IDX_W-1:0]    del_i_reg, del_i_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [7:0]          key_i_reg, key_i_next;
    logic                listed_i_reg, listed_i_next;
    logic [RANK_W-1:0]   rank_reg, rank_next;
    logic                in_range_reg, in_range_next;
    logic [3:0]          res_slot_reg, res_slot_next;
    logic [7:0]          res_stamp_reg, res_stamp_next;
    logic                res_status_reg, res_status_next;
    logic                res_ren_reg, res_ren_next;
    logic                out_valid_reg, out_valid_next;
    logic [3:0]          out_slot_reg, out_slot_next;
    logic [7:0]          out_stamp_reg, out_stamp_next;
    logic                out_status_reg, out_status_next;
    logic                out_ren_reg, out_ren_next;

    // Stamp store and compare unit hookup
    ast_pkg::st_ctl_t    st_ctl;
    logic [IDX_W-1:0]    st_wr_addr;
    logic [IDX_W-1:0]    st_rd_addr;
    logic [7:0]          st_rd_data;
    ast_pkg::cmp_res_t   cmp;
    logic [IDX_W-1:0]    cmp_idx;

    // Rank memory
    logic [RANK_W-1:0]   rank_mem [SLOT_COUNT];
    logic [RANK_W-1:0]   rank_q_reg;
    logic                rank_we;
    logic [RANK_W-1:0]   rank_wdata;

    // Derived indexes
    logic [CNT_W-1:0]    cnt_m1;
    logic [IDX_W-1:0]    proc_idx;
    logic [IDX_W-1:0]    issue_addr;
    logic [IDX_W+3:0]    si_wide;
    logic [IDX_W-1:0]    si_addr;
    logic                si_in_range;
    logic [IDX_W-1:0]    sel_idx;
    logic                sel_found;
    logic [IDX_W+3:0]    sel_wide;
    logic [RANK_W-1:0]   rank_fin;
    logic [7:0]          rank_fin_ext;
    logic [7:0]          rank_q_ext;
    logic                req_acc;

    assign cnt_m1      = cnt_reg - CNT_W'(1);
    assign proc_idx    = cnt_m1[IDX_W-1:0];
    assign issue_addr  = (cnt_reg < LAST_CNT) ? cnt_reg[IDX_W-1:0] : '0;
    assign si_wide     = {{IDX_W{1'b0}}, request.slot_index};
    assign si_addr     = si_wide[IDX_W-1:0];
    assign si_in_range = (32'(request.slot_index) < SLOT_COUNT);
    assign req_acc     = request.valid && request.ready;
    assign cmp_idx     = (state_reg == S_RN_KEY) ? oi_reg : proc_idx;
    assign rank_fin     = rank_reg + RANK_W'(cmp.listed && cmp.before_ref);
    assign rank_fin_ext = {{(8-RANK_W){1'b0}}, rank_fin};
    assign rank_q_ext   = {{(8-RANK_W){1'b0}}, rank_q_reg};

    ast_stamp_store #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (st_ctl),
        .wr_addr (st_wr_addr),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    ast_cmp_unit #(
        .IDX_W (IDX_W)
    ) u_cmp (
        .stamp      (st_rd_data),
        .cur_idx    (cmp_idx),
        .chosen_idx (idx_reg),
        .min_s      (min_s_reg),
        .max_s      (max_s_reg),
        .ref_key    (key_i_reg),
        .ref_idx    (oi_reg),
        .res        (cmp)
    );

    // Put slot selection: empty, then deleted when reuse is on, then oldest live
    always_comb
    begin
        sel_found = 1'b1;
        sel_idx   = min_i_reg;
        if (have_empty_reg)
        begin
            sel_idx = empty_i_reg;
        end
        else if (have_del_reg && reuse_reg)
        begin
            sel_idx = del_i_reg;
        end
        else if (!have_min_reg)
        begin
            sel_found = 1'b0;
        end
    end

    assign sel_wide = {4'b0000, sel_idx};

    // Rank memory: write and registered read
    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[oi_reg] <= rank_wdata;
        end
        rank_q_reg <= rank_mem[issue_addr];
    end

    // Sequencer next-state logic
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        oi_next         = oi_reg;
        min_s_next      = min_s_reg;
        min_i_next      = min_i_reg;
        have_min_next   = have_min_reg;
        max_s_next      = max_s_reg;
        have_empty_next = have_empty_reg;
        empty_i_next    = empty_i_reg;
        have_del_next   = have_del_reg;
        del_i_next      = del_i_reg;
        idx_next        = idx_reg;
        key_i_next      = key_i_reg;
        listed_i_next   = listed_i_reg;
        rank_next       = rank_reg;
        in_range_next   = in_range_reg;
        res_slot_next   = res_slot_reg;
        res_stamp_next  = res_stamp_reg;
        res_status_next = res_status_reg;
        res_ren_next    = res_ren_reg;
        out_valid_next  = out_valid_reg && !response.ready;
        out_slot_next   = out_slot_reg;
        out_stamp_next  = out_stamp_reg;
        out_status_next = out_status_reg;
        out_ren_next    = out_ren_reg;
        st_ctl          = '0;
        st_wr_addr      = '0;
        st_rd_addr      = '0;
        rank_we         = 1'b0;
        rank_wdata      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    res_status_next = ast_pkg::STATUS_OK;
                    res_ren_next    = 1'b0;
                    unique case (ast_pkg::cmd_t'(request.command))
                        ast_pkg::CMD_PUT:
                        begin
                            cnt_next        = '0;
                            have_min_next   = 1'b0;
                            have_empty_next = 1'b0;
                            have_del_next   = 1'b0;
                            max_s_next      = 8'd0;
                            state_next      = S_SCAN;
                        end
                        ast_pkg::CMD_DELETE:
                        begin
                            st_ctl.wr_en   = si_in_range;
                            st_ctl.wr_data = ast_pkg::STAMP_DELETED;
                            st_wr_addr     = si_addr;
                            res_slot_next  = request.slot_index;
                            res_stamp_next = ast_pkg::STAMP_DELETED;
                            state_next     = S_FIN;
                        end
                        ast_pkg::CMD_READ:
                        begin
                            st_rd_addr    = si_in_range ? si_addr : '0;
                            in_range_next = si_in_range;
                            res_slot_next = request.slot_index;
                            state_next    = S_READ;
                        end
                        ast_pkg::CMD_CLEAR:
                        begin
                            st_ctl.clear   = 1'b1;
                            res_slot_next  = 4'd0;
                            res_stamp_next = ast_pkg::STAMP_EMPTY;
                            state_next     = S_FIN;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                res_stamp_next = in_range_reg ? st_rd_data : ast_pkg::STAMP_EMPTY;
                state_next     = S_FIN;
            end

            // one slot per cycle: issue read of cnt, process data of cnt-1
            S_SCAN:
            begin
                st_rd_addr = issue_addr;
                if (cnt_reg != '0)
                begin
                    if (cmp.is_live && (!have_min_reg || cmp.lt_min))
                    begin
                        min_s_next    = st_rd_data;
                        min_i_next    = proc_idx;
                        have_min_next = 1'b1;
                    end
                    if (!cmp.is_empty && cmp.gt_max)
                    begin
                        max_s_next = st_rd_data;
                    end
                    if (cmp.is_empty && !have_empty_reg)
                    begin
                        have_empty_next = 1'b1;
                        empty_i_next    = proc_idx;
                    end
                    if (cmp.is_deleted && !have_del_reg)
                    begin
                        have_del_next = 1'b1;
                        del_i_next    = proc_idx;
                    end
                end
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            S_DECIDE:
            begin
                idx_next      = sel_idx;
                res_slot_next = sel_wide[3:0];
                if (!sel_found)
                begin
                    res_slot_next   = 4'd0;
                    res_stamp_next  = 8'd0;
                    res_status_next = ast_pkg::STATUS_NO_SLOT;
                    state_next      = S_FIN;
                end
                else if (max_s_reg < ast_pkg::STAMP_MAX_LIVE)
                begin
                    st_ctl.wr_en   = 1'b1;
                    st_ctl.wr_data = max_s_reg + 8'd1;
                    st_wr_addr     = sel_idx;
                    res_stamp_next = max_s_reg + 8'd1;
                    state_next     = S_FIN;
                end
                else
                begin
                    res_ren_next = 1'b1;
                    oi_next      = '0;
                    state_next   = S_RN_LOAD;
                end
            end

            S_RN_LOAD:
            begin
                st_rd_addr = oi_reg;
                state_next = S_RN_KEY;
            end

            S_RN_KEY:
            begin
                key_i_next    = cmp.key;
                listed_i_next = cmp.listed;
                rank_next     = RANK_W'(1);
                cnt_next      = '0;
                state_next    = S_RN_INNER;
            end

            // count listed slots ordered before slot oi
            S_RN_INNER:
            begin
                st_rd_addr = issue_addr;
                if (cnt_reg != '0)
                begin
                    rank_next = rank_fin;
                end
                if (cnt_reg == LAST_CNT)
                begin
                    rank_we    = 1'b1;
                    rank_wdata = listed_i_reg ? rank_fin : '0;
                    if (oi_reg == idx_reg)
                    begin
                        res_stamp_next = rank_fin_ext;
                    end
                    if (oi_reg == LAST_IDX)
                    begin
                        cnt_next   = '0;
                        state_next = S_COPY;
                    end
                    else
                    begin
                        oi_next    = oi_reg + IDX_W'(1);
                        state_next = S_RN_LOAD;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            // write ranks back; rank zero marks a slot left alone
            S_COPY:
            begin
                if (cnt_reg != '0)
                begin
                    st_ctl.wr_en   = (rank_q_reg != '0);
                    st_ctl.wr_data = rank_q_ext;
                    st_wr_addr     = proc_idx;
                end
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || response.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_slot_next   = res_slot_reg;
                    out_stamp_next  = res_stamp_reg;
                    out_status_next = res_status_reg;
                    out_ren_next    = res_ren_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, registered outputs and the reuse configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            out_slot_reg   <= 4'd0;
            out_stamp_reg  <= 8'd0;
            out_status_reg <= ast_pkg::STATUS_OK;
            out_ren_reg    <= 1'b0;
            reuse_reg      <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            out_slot_reg   <= out_slot_next;
            out_stamp_reg  <= out_stamp_next;
            out_status_reg <= out_status_next;
            out_ren_reg    <= out_ren_next;
            if (cfg_wr_en)
            begin
                reuse_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        oi_reg         <= oi_next;
        min_s_reg      <= min_s_next;
        min_i_reg      <= min_i_next;
        have_min_reg   <= have_min_next;
        max_s_reg      <= max_s_next;
        have_empty_reg <= have_empty_next;
        empty_i_reg    <= empty_i_next;
        have_del_reg   <= have_del_next;
        del_i_reg      <= del_i_next;
        idx_reg        <= idx_next;
        key_i_reg      <= key_i_next;
        listed_i_reg   <= listed_i_next;
        rank_reg       <= rank_next;
        in_range_reg   <= in_range_next;
        res_slot_reg   <= res_slot_next;
        res_stamp_reg  <= res_stamp_next;
        res_status_reg <= res_status_next;
        res_ren_reg    <= res_ren_next;
    end

    assign request.ready        = (state_reg == S_IDLE);
    assign response.valid       = out_valid_reg;
    assign response.slot        = out_slot_reg;
    assign response.entry_stamp = out_stamp_reg;
    assign response.status      = out_status_reg;
    assign response.renumbered  = out_ren_reg;

    // Assertions
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !request.ready)
        else $error("request ready right after an accepted transaction");

    a_copy_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY) && st_ctl.wr_en |-> (32'(rank_q_reg) <= SLOT_COUNT))
        else $error("renumbered stamp exceeds slot count");

    a_renumber_result: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid && response.renumbered |->
            (response.status == ast_pkg::STATUS_OK) && (response.entry_stamp != 8'd0) &&
            (32'(response.entry_stamp) <= SLOT_COUNT))
        else $error("renumbered put returned an out-of-range stamp");

    a_no_slot_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) && !sel_found |=>
            (state_reg == S_FIN) && (res_status_reg == ast_pkg::STATUS_NO_SLOT) &&
            !res_ren_reg)
        else $error("failed put did not report no usable slot");

endmodule

// File: tb/sv/tb.sv
// Testbench for age_stamped_slot_table: directed and random command streams, checked
// against an in-bench model of the stamp table. Depends on ast_pkg, ast_cmd_if,
// ast_res_if and the RTL of the table.
module tb;

    localparam int SLOT_COUNT   = 16;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 400;
    localparam int MAX_PRINTS   = 40;

    // One result of the table
    typedef struct packed {
        logic [3:0] slot;
        logic [7:0] entry_stamp;
        logic       status;
        logic       renumbered;
    } table_result_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    ast_cmd_if request_ch ();
    ast_res_if result_ch ();

    age_stamped_slot_table #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (request_ch),
        .response    (result_ch)
    );

    // Model of the table
    logic [7:0]    table_stamps [SLOT_COUNT];
    logic          reuse_on;
    table_result_t expected_results [$];
    table_result_t got_result;
    table_result_t want_result;

    int error_count;
    int put_count;
    int renumber_count;
    int no_slot_count;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit live_stamp(logic [7:0] s);
        return s != ast_pkg::STAMP_EMPTY && s != ast_pkg::STAMP_DELETED;
    endfunction

    // Put: choose a slot, stamp it, renumber when the stamps run out
    function automatic table_result_t predict_put();
        table_result_t r;
        int            i;
        int            k;
        int            min_s;
        int            max_s;
        int            min_i;
        int            empty_i;
        int            del_i;
        int            pick;
        int            rank;
        logic [7:0]    key [SLOT_COUNT];
        bit            listed [SLOT_COUNT];
        logic [7:0]    ranked [SLOT_COUNT];
        min_s   = 256;
        max_s   = 0;
        min_i   = -1;
        empty_i = -1;
        del_i   = -1;
        r       = '0;
        for (i = 0; i < SLOT_COUNT; i++)
        begin
            if (live_stamp(table_stamps[i]) && table_stamps[i] < min_s)
            begin
                min_s = table_stamps[i];
                min_i = i;
            end
            if (table_stamps[i] != ast_pkg::STAMP_EMPTY && table_stamps[i] > max_s)
                max_s = table_stamps[i];
            if (table_stamps[i] == ast_pkg::STAMP_EMPTY && empty_i < 0)
                empty_i = i;
            if (table_stamps[i] == ast_pkg::STAMP_DELETED && del_i < 0)
                del_i = i;
        end
        if (empty_i >= 0)
            pick = empty_i;
        else if (del_i >= 0 && reuse_on)
            pick = del_i;
        else if (min_i >= 0)
            pick = min_i;
        else
        begin
            r.status = ast_pkg::STATUS_NO_SLOT;
            no_slot_count++;
            return r;
        end
        r.status = ast_pkg::STATUS_OK;
        r.slot   = pick[3:0];
        if (max_s < ast_pkg::STAMP_MAX_LIVE)
        begin
            table_stamps[pick] = max_s[7:0] + 8'd1;
            r.entry_stamp      = table_stamps[pick];
            return r;
        end
        // Renumber live slots plus the chosen one by (stamp, slot); chosen ranks last
        for (i = 0; i < SLOT_COUNT; i++)
        begin
            listed[i] = (i == pick) || live_stamp(table_stamps[i]);
            key[i]    = (i == pick) ? ast_pkg::STAMP_EMPTY : table_stamps[i];
        end
        for (i = 0; i < SLOT_COUNT; i++)
        begin
            ranked[i] = table_stamps[i];
            if (listed[i])
            begin
                rank = 1;
                for (k = 0; k < SLOT_COUNT; k++)
                    if (listed[k] && k != i && (key[k] < key[i] || (key[k] == key[i] && k < i)))
                        rank++;
                ranked[i] = rank[7:0];
            end
        end
        table_stamps  = ranked;
        r.entry_stamp = table_stamps[pick];
        r.renumbered  = 1'b1;
        renumber_count++;
        return r;
    endfunction

    function automatic table_result_t predict_table_op(ast_pkg::cmd_t c, logic [3:0] idx);
        table_result_t r;
        int            i;
        r        = '0;
        r.status = ast_pkg::STATUS_OK;
        case (c)
            ast_pkg::CMD_PUT:
            begin
                put_count++;
                r = predict_put();
            end
            ast_pkg::CMD_DELETE:
            begin
                r.slot            = idx;
                r.entry_stamp     = ast_pkg::STAMP_DELETED;
                table_stamps[idx] = ast_pkg::STAMP_DELETED;
            end
            ast_pkg::CMD_READ:
            begin
                r.slot        = idx;
                r.entry_stamp = table_stamps[idx];
            end
            default:
            begin
                for (i = 0; i < SLOT_COUNT; i++)
                    table_stamps[i] = ast_pkg::STAMP_EMPTY;
                r.entry_stamp = ast_pkg::STAMP_EMPTY;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (error_count < MAX_PRINTS)
            $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Send one transaction; valid stays high unless the next one idles first or a drain drops it
    task automatic send_op(ast_pkg::cmd_t c, logic [3:0] idx);
        while ($urandom_range(99) < idle_pct)
        begin
            request_ch.valid <= 1'b0;
            @(posedge clk);
        end
        request_ch.valid      <= 1'b1;
        request_ch.command    <= c;
        request_ch.slot_index <= idx;
        do
            @(posedge clk);
        while (!request_ch.ready);
        expected_results.push_back(predict_table_op(c, idx));
    endtask

    // Hold off the request side until every result is back
    task automatic drain_results();
        request_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_reuse(logic v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        reuse_on  = v;
    endtask

    function automatic ast_pkg::cmd_t pick_cmd(int put_w, int del_w, int read_w);
        int roll;
        roll = $urandom_range(99);
        if (roll < put_w)
            return ast_pkg::CMD_PUT;
        if (roll < put_w + del_w)
            return ast_pkg::CMD_DELETE;
        if (roll < put_w + del_w + read_w)
            return ast_pkg::CMD_READ;
        return ast_pkg::CMD_CLEAR;
    endfunction

    task automatic send_random(int count, int put_w, int del_w, int read_w);
        int n;
        for (n = 0; n < count; n++)
        begin
            send_op(pick_cmd(put_w, del_w, read_w), 4'($urandom_range(SLOT_COUNT - 1)));
            if ($urandom_range(59) == 0)
                drain_results();
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (result_ch.valid && result_ch.ready)
        begin
            got_result = {result_ch.slot, result_ch.entry_stamp, result_ch.status,
                          result_ch.renumbered};
            if (expected_results.size() == 0)
                report_mismatch("result with nothing pending, slot", got_result.slot, 0);
            else
            begin
                want_result = expected_results.pop_front();
                if (got_result.slot !== want_result.slot)
                    report_mismatch("slot", got_result.slot, want_result.slot);
                if (got_result.entry_stamp !== want_result.entry_stamp)
                    report_mismatch("entry_stamp", got_result.entry_stamp,
                                    want_result.entry_stamp);
                if (got_result.status !== want_result.status)
                    report_mismatch("status", got_result.status, want_result.status);
                if (got_result.renumbered !== want_result.renumbered)
                    report_mismatch("renumbered", got_result.renumbered,
                                    want_result.renumbered);
            end
        end
    end

    // Response back-pressure
    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready)
            || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout after %0d quiet cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Reset contents: a first lookup of slot 0
    task automatic test_reset_state();
        send_op(ast_pkg::CMD_READ, 4'd0);
    endtask

    // Put, delete of an empty slot, read back, put skipping a deleted slot, clear
    task automatic test_basic_ops();
        send_op(ast_pkg::CMD_PUT, 4'd7);
        send_op(ast_pkg::CMD_PUT, 4'd0);
        send_op(ast_pkg::CMD_DELETE, 4'd15);
        send_op(ast_pkg::CMD_READ, 4'd15);
        send_op(ast_pkg::CMD_DELETE, 4'd0);
        send_op(ast_pkg::CMD_PUT, 4'd3);
        send_op(ast_pkg::CMD_CLEAR, 4'd9);
    endtask

    // Every slot deleted with reuse off, then reuse back on
    task automatic test_no_usable_slot();
        int i;
        set_reuse(1'b0);
        for (i = 0; i < SLOT_COUNT; i++)
            send_op(ast_pkg::CMD_DELETE, 4'(i));
        send_op(ast_pkg::CMD_PUT, 4'd0);
        set_reuse(1'b1);
        send_op(ast_pkg::CMD_PUT, 4'd15);
    endtask

    // Long put-heavy run with no clear so stamps wrap and renumber
    task automatic test_age_rollover();
        set_reuse(1'b1);
        idle_pct  = 0;
        stall_pct = 0;
        send_random(200, 70, 15, 15);
        idle_pct  = 8;
        stall_pct = 8;
        send_random(300, 70, 15, 15);
    endtask

    // Eviction of the oldest live entry with reuse off
    task automatic test_evict_oldest();
        set_reuse(1'b0);
        send_random(450, 65, 20, 14);
    endtask

    // All slots deleted in random order, puts with each reuse setting
    task automatic test_all_deleted();
        int order [SLOT_COUNT];
        int i;
        int j;
        int tmp;
        int round;
        for (round = 0; round < 4; round++)
        begin
            set_reuse(1'b0);
            for (i = 0; i < SLOT_COUNT; i++)
                order[i] = i;
            for (i = SLOT_COUNT - 1; i > 0; i--)
            begin
                j        = $urandom_range(i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (i = 0; i < SLOT_COUNT; i++)
                send_op(ast_pkg::CMD_DELETE, 4'(order[i]));
            send_op(ast_pkg::CMD_PUT, 4'($urandom_range(SLOT_COUNT - 1)));
            send_op(ast_pkg::CMD_READ, 4'($urandom_range(SLOT_COUNT - 1)));
            send_op(ast_pkg::CMD_PUT, 4'($urandom_range(SLOT_COUNT - 1)));
            set_reuse(1'b1);
            send_random(8, 60, 10, 30);
        end
    endtask

    // Everything mixed, reuse and idling changed between blocks
    task automatic test_random_mix();
        int blk;
        for (blk = 0; blk < 6; blk++)
        begin
            set_reuse(blk[0]);
            idle_pct  = ($urandom_range(2) == 0) ? 0 : 8;
            stall_pct = ($urandom_range(2) == 0) ? 0 : 8;
            send_random(95, 55, 22, 20);
        end
    endtask

    // Main sequence
    initial
    begin
        int i;
        rst_n                 <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_wr_data           <= 1'b0;
        request_ch.valid      <= 1'b0;
        request_ch.command    <= ast_pkg::CMD_PUT;
        request_ch.slot_index <= '0;
        error_count    = 0;
        put_count      = 0;
        renumber_count = 0;
        no_slot_count  = 0;
        idle_pct       = 8;
        stall_pct      = 8;
        reuse_on       = 1'b1;
        for (i = 0; i < SLOT_COUNT; i++)
            table_stamps[i] = ast_pkg::STAMP_EMPTY;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_basic_ops();
        test_no_usable_slot();
        test_age_rollover();
        test_evict_oldest();
        test_all_deleted();
        test_random_mix();

        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", 0, expected_results.size());

        $display("Covered %0d puts, %0d with renumbering, %0d with no usable slot,",
                 put_count, renumber_count, no_slot_count);
        $display("plus deletes, reads and clears under both reuse settings; %0d mismatches",
                 error_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: age_stamped_slot_table.f
rtl/ast_pkg.sv
rtl/ast_cmd_if.sv
rtl/ast_res_if.sv
rtl/ast_stamp_store.sv
rtl/ast_cmp_unit.sv
rtl/age_stamped_slot_table.sv
tb/sv/tb.sv
